/* sv/mtgd_pkg.sv */
// ----------------------------------------------------------------------------
// mtgd_pkg: shared types and constants for the millisecond to date converter
// Divider request/response structs, per-step divisor, reciprocal, shift and
// byte count, and the month length table.
// ----------------------------------------------------------------------------
package mtgd_pkg;

	localparam int DATA_W  = 64;
	localparam int DIG_W   = 4;
	localparam int DVS_W   = 18;
	localparam int RCP_W   = 27;
	localparam int SHF_W   = 6;
	localparam int VAL_W   = DVS_W + 8;
	localparam int PROD_W  = VAL_W + RCP_W;
	localparam int YEAR_W  = 30;
	localparam int DOY_W   = 9;
	localparam int Q400_W  = 21;

	localparam logic [DVS_W-1:0] MS_PER_S   = DVS_W'(1000);
	localparam logic [DVS_W-1:0] S_PER_MIN  = DVS_W'(60);
	localparam logic [DVS_W-1:0] MIN_PER_H  = DVS_W'(60);
	localparam logic [DVS_W-1:0] H_PER_DAY  = DVS_W'(24);
	localparam logic [DVS_W-1:0] DAYS_400Y  = DVS_W'(400 * 365 + 100 - 4 + 1);
	localparam logic [DVS_W-1:0] DAYS_100Y  = DVS_W'(100 * 365 + 25 - 1);
	localparam logic [DVS_W-1:0] DAYS_4Y    = DVS_W'(4 * 365 + 1);
	localparam logic [DVS_W-1:0] DAYS_1Y    = DVS_W'(365);

	// Reciprocals ceil(2^s / d) with s = 2 * ceil(log2 d) + 8, exact for one byte step
	localparam logic [RCP_W-1:0] RCP_MS     = RCP_W'(268436);
	localparam logic [RCP_W-1:0] RCP_60     = RCP_W'(17477);
	localparam logic [RCP_W-1:0] RCP_HR     = RCP_W'(10923);
	localparam logic [RCP_W-1:0] RCP_400Y   = RCP_W'(120414424);
	localparam logic [RCP_W-1:0] RCP_100Y   = RCP_W'(30103812);
	localparam logic [RCP_W-1:0] RCP_4Y     = RCP_W'(734937);
	localparam logic [RCP_W-1:0] RCP_1Y     = RCP_W'(183860);

	// Division steps, in the order the sequencer runs them
	typedef enum logic [2:0] {
		STEP_MS, STEP_SEC, STEP_MIN, STEP_HR,
		STEP_400Y, STEP_100Y, STEP_4Y, STEP_1Y
	} step_t;

	typedef struct packed {
		logic              start;
		logic [DATA_W-1:0] dividend;
		logic [DVS_W-1:0]  divisor;
		logic [RCP_W-1:0]  recip;
		logic [SHF_W-1:0]  shift;
		logic [DIG_W-1:0]  ndig;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DATA_W-1:0] quot;
		logic [DVS_W-1:0]  rem;
	} div_rsp_t;

	function automatic logic [DVS_W-1:0] step_divisor(step_t s);
		logic [DVS_W-1:0] d;
		case (s)
			STEP_MS:   d = MS_PER_S;
			STEP_SEC:  d = S_PER_MIN;
			STEP_MIN:  d = MIN_PER_H;
			STEP_HR:   d = H_PER_DAY;
			STEP_400Y: d = DAYS_400Y;
			STEP_100Y: d = DAYS_100Y;
			STEP_4Y:   d = DAYS_4Y;
			STEP_1Y:   d = DAYS_1Y;
			default:   d = DAYS_1Y;
		endcase
		return d;
	endfunction

	function automatic logic [RCP_W-1:0] step_recip(step_t s);
		logic [RCP_W-1:0] r;
		case (s)
			STEP_MS:   r = RCP_MS;
			STEP_SEC:  r = RCP_60;
			STEP_MIN:  r = RCP_60;
			STEP_HR:   r = RCP_HR;
			STEP_400Y: r = RCP_400Y;
			STEP_100Y: r = RCP_100Y;
			STEP_4Y:   r = RCP_4Y;
			STEP_1Y:   r = RCP_1Y;
			default:   r = RCP_1Y;
		endcase
		return r;
	endfunction

	// Right shift that goes with each reciprocal
	function automatic logic [SHF_W-1:0] step_shift(step_t s);
		logic [SHF_W-1:0] n;
		case (s)
			STEP_MS:   n = SHF_W'(28);
			STEP_SEC:  n = SHF_W'(20);
			STEP_MIN:  n = SHF_W'(20);
			STEP_HR:   n = SHF_W'(18);
			STEP_400Y: n = SHF_W'(44);
			STEP_100Y: n = SHF_W'(40);
			STEP_4Y:   n = SHF_W'(30);
			STEP_1Y:   n = SHF_W'(26);
			default:   n = SHF_W'(26);
		endcase
		return n;
	endfunction

	// Bytes of dividend that can be nonzero at each step
	function automatic logic [DIG_W-1:0] step_ndig(step_t s);
		logic [DIG_W-1:0] n;
		case (s)
			STEP_MS:   n = DIG_W'(8);
			STEP_SEC:  n = DIG_W'(7);
			STEP_MIN:  n = DIG_W'(7);
			STEP_HR:   n = DIG_W'(6);
			STEP_400Y: n = DIG_W'(5);
			STEP_100Y: n = DIG_W'(3);
			STEP_4Y:   n = DIG_W'(2);
			STEP_1Y:   n = DIG_W'(2);
			default:   n = DIG_W'(8);
		endcase
		return n;
	endfunction

	// Month length, February without the leap day
	function automatic logic [4:0] month_days(logic [3:0] m);
		logic [4:0] d;
		case (m)
			4'd2:                      d = 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:   d = 5'd30;
			default:                   d = 5'd31;
		endcase
		return d;
	endfunction

endpackage

/* sv/mtgd_div.sv */
// ----------------------------------------------------------------------------
// mtgd_div: shared constant divider
// Long division a byte at a time: one shared multiplier forms each quotient
// byte from a reciprocal of the divisor, then the byte times the divisor for
// the remainder, each byte in the multiply, select, multiply back and subtract
// phases. Quotient and remainder hold after the done pulse until the next start.
// ----------------------------------------------------------------------------
module mtgd_div (
	input  logic               clk,
	input  logic               arst_n,
	input  mtgd_pkg::div_req_t req,
	output mtgd_pkg::div_rsp_t rsp
);
	import mtgd_pkg::*;

	typedef enum logic [2:0] {P_IDLE, P_MUL_Q, P_SEL_Q, P_MUL_R, P_SUB} phase_t;

	phase_t            phase_q;
	logic [DATA_W-1:0] a_q;
	logic [DVS_W-1:0]  r_q;
	logic [DVS_W-1:0]  dvs_q;
	logic [RCP_W-1:0]  rcp_q;
	logic [SHF_W-1:0]  shf_q;
	logic [DIG_W-1:0]  cnt_q;
	logic [7:0]        qd_q;
	logic [PROD_W-1:0] prod_q;
	logic              done_q;
	logic [6:0]        lsh;
	logic [VAL_W-1:0]  val;
	logic [VAL_W-1:0]  mul_a;
	logic [RCP_W-1:0]  mul_b;
	logic [PROD_W-1:0] prod;
	logic [PROD_W-1:0] prod_sh;
	logic [VAL_W-1:0]  rdiff;

	// Partial remainder with the next byte, shared multiplier and remainder subtract
	always_comb begin
		lsh     = 7'(DATA_W) - {req.ndig, 3'b000};
		val     = {r_q, a_q[DATA_W-1 -: 8]};
		mul_a   = (phase_q == P_MUL_R) ? VAL_W'(qd_q) : val;
		mul_b   = (phase_q == P_MUL_R) ? RCP_W'(dvs_q) : rcp_q;
		prod    = PROD_W'(mul_a) * PROD_W'(mul_b);
		prod_sh = prod_q >> shf_q;
		rdiff   = val - prod_q[VAL_W-1:0];
	end

	// Byte sequencer: multiply, pick quotient byte, multiply back, subtract
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= P_IDLE;
			a_q     <= '0;
			r_q     <= '0;
			dvs_q   <= '0;
			rcp_q   <= '0;
			shf_q   <= '0;
			cnt_q   <= '0;
			qd_q    <= '0;
			prod_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (phase_q)
				P_IDLE: begin
					if (req.start) begin
						a_q     <= req.dividend << lsh;
						r_q     <= '0;
						dvs_q   <= req.divisor;
						rcp_q   <= req.recip;
						shf_q   <= req.shift;
						cnt_q   <= req.ndig;
						phase_q <= P_MUL_Q;
					end
				end
				P_MUL_Q: begin
					prod_q  <= prod;
					phase_q <= P_SEL_Q;
				end
				P_SEL_Q: begin
					qd_q    <= prod_sh[7:0];
					phase_q <= P_MUL_R;
				end
				P_MUL_R: begin
					prod_q  <= prod;
					phase_q <= P_SUB;
				end
				P_SUB: begin
					r_q   <= rdiff[DVS_W-1:0];
					a_q   <= {a_q[DATA_W-9:0], qd_q};
					cnt_q <= cnt_q - DIG_W'(1);
					if (cnt_q == DIG_W'(1)) begin
						done_q  <= 1'b1;
						phase_q <= P_IDLE;
					end else begin
						phase_q <= P_MUL_Q;
					end
				end
				default: begin
					phase_q <= P_IDLE;
				end
			endcase
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = a_q;
	assign rsp.rem  = r_q;

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> r_q < dvs_q)
		else $error("divider remainder not below divisor");

	a_digit_fits: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == P_SEL_Q |-> prod_sh[PROD_W-1:8] == '0)
		else $error("quotient byte overflow");

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> phase_q == P_IDLE)
		else $error("divider started while busy");

	a_done_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("divider done held more than one cycle");

endmodule

/* sv/millis_to_gregorian_date_top.sv */
// Each item runs through eight divisions (40 bytes of division in all), the year
// stage, the month walk and the load of the output register; that load waits while
// the output register holds a result that out_ready has not yet taken.
// One shared divider serves every step; a new item is taken only back in S_IDLE.
// A new item is taken while the previous result still waits in the output register.
// Reset (arst_n, asynchronous, active low) clears the sequencer and output valid.
// ----------------------------------------------------------------------------
// millis_to_gregorian_date_top: millisecond count to Gregorian date and time
// Sequences one shared divider through time-of-day and calendar-cycle
// divisions, then derives the year and walks the month table.
// ----------------------------------------------------------------------------
module millis_to_gregorian_date_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [63:0]                   time_ms,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [mtgd_pkg::YEAR_W-1:0]   year,
	output logic [3:0]                    month,
	output logic [4:0]                    day,
	output logic [4:0]                    hour,
	output logic [5:0]                    minute,
	output logic [5:0]                    second,
	output logic [9:0]                    millisecond
);
	import mtgd_pkg::*;

	typedef enum logic [2:0] {S_IDLE, S_DIV, S_YEAR, S_MONTH, S_DONE} state_t;

	state_t              state_q;
	step_t               step_q;
	logic                start_q;
	logic [DATA_W-1:0]   dvd_q;
	logic [9:0]          ms_q;
	logic [5:0]          sec_q;
	logic [5:0]          min_q;
	logic [4:0]          hr_q;
	logic [Q400_W-1:0]   q400_q;
	logic [1:0]          q100_q;
	logic [4:0]          q4_q;
	logic [1:0]          q1_q;
	logic [DOY_W-1:0]    doy_q;
	logic [3:0]          mon_q;
	logic                leap_q;
	logic [YEAR_W-1:0]   year_q;
	logic                out_valid_q;

	div_req_t            div_req;
	div_rsp_t            div_rsp;
	logic                clamp_hit;
	logic [DVS_W-1:0]    rem_fix;
	logic [1:0]          q_fix;
	logic [4:0]          mlen;
	logic [YEAR_W-1:0]   year_sum;

	mtgd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Drive the divider from the current step
	always_comb begin
		div_req.start    = start_q;
		div_req.dividend = dvd_q;
		div_req.divisor  = step_divisor(step_q);
		div_req.recip    = step_recip(step_q);
		div_req.shift    = step_shift(step_q);
		div_req.ndig     = step_ndig(step_q);
	end

	// Clamp the last day of a long cycle back into cycle index three
	always_comb begin
		clamp_hit = div_rsp.quot[2:0] == 3'd4;
		rem_fix   = clamp_hit ? div_rsp.rem + step_divisor(step_q) : div_rsp.rem;
		q_fix     = clamp_hit ? 2'd3 : div_rsp.quot[1:0];
	end

	// Year from the cycle counts, 400 * q400 as shift-adds
	always_comb begin
		year_sum = (YEAR_W'(q400_q) << 8) + (YEAR_W'(q400_q) << 7)
			+ (YEAR_W'(q400_q) << 4) + YEAR_W'(q100_q) * YEAR_W'(100)
			+ (YEAR_W'(q4_q) << 2) + YEAR_W'(q1_q) + YEAR_W'(1);
	end

	// Length of the month under test, leap day added to February
	always_comb begin
		mlen = month_days(mon_q) + ((mon_q == 4'd2 && leap_q) ? 5'd1 : 5'd0);
	end

	// Sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= STEP_MS;
			start_q     <= 1'b0;
			dvd_q       <= '0;
			ms_q        <= '0;
			sec_q       <= '0;
			min_q       <= '0;
			hr_q        <= '0;
			q400_q      <= '0;
			q100_q      <= '0;
			q4_q        <= '0;
			q1_q        <= '0;
			doy_q       <= '0;
			mon_q       <= '0;
			leap_q      <= 1'b0;
			year_q      <= '0;
			out_valid_q <= 1'b0;
			year        <= '0;
			month       <= '0;
			day         <= '0;
			hour        <= '0;
			minute      <= '0;
			second      <= '0;
			millisecond <= '0;
		end else begin
			start_q <= 1'b0;
			// Drop output valid after its transfer; S_DONE reloads it itself
			if (out_valid_q && out_ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						dvd_q   <= time_ms;
						step_q  <= STEP_MS;
						start_q <= 1'b1;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_rsp.done) begin
						case (step_q)
							STEP_MS: begin
								ms_q  <= div_rsp.rem[9:0];
								dvd_q <= div_rsp.quot;
							end
							STEP_SEC: begin
								sec_q <= div_rsp.rem[5:0];
								dvd_q <= div_rsp.quot;
							end
							STEP_MIN: begin
								min_q <= div_rsp.rem[5:0];
								dvd_q <= div_rsp.quot;
							end
							STEP_HR: begin
								hr_q  <= div_rsp.rem[4:0];
								dvd_q <= div_rsp.quot;
							end
							STEP_400Y: begin
								q400_q <= div_rsp.quot[Q400_W-1:0];
								dvd_q  <= DATA_W'(div_rsp.rem);
							end
							STEP_100Y: begin
								q100_q <= q_fix;
								dvd_q  <= DATA_W'(rem_fix);
							end
							STEP_4Y: begin
								q4_q  <= div_rsp.quot[4:0];
								dvd_q <= DATA_W'(div_rsp.rem);
							end
							STEP_1Y: begin
								q1_q  <= q_fix;
								doy_q <= rem_fix[DOY_W-1:0] + DOY_W'(1);
							end
							default: begin
								dvd_q <= div_rsp.quot;
							end
						endcase
						if (step_q == STEP_1Y) begin
							state_q <= S_YEAR;
						end else begin
							step_q  <= step_t'(step_q + 3'd1);
							start_q <= 1'b1;
						end
					end
				end
				S_YEAR: begin
					year_q  <= year_sum;
					leap_q  <= q1_q == 2'd3 && (q4_q != 5'd24 || q100_q == 2'd3);
					mon_q   <= 4'd1;
					state_q <= S_MONTH;
				end
				S_MONTH: begin
					// Stop when the day fits this month or December is reached
					if (doy_q <= DOY_W'(mlen) || mon_q == 4'd12) begin
						state_q <= S_DONE;
					end else begin
						doy_q <= doy_q - DOY_W'(mlen);
						mon_q <= mon_q + 4'd1;
					end
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						year        <= year_q;
						month       <= mon_q;
						day         <= doy_q[4:0];
						hour        <= hr_q;
						minute      <= min_q;
						second      <= sec_q;
						millisecond <= ms_q;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready  = state_q == S_IDLE;
	assign out_valid = out_valid_q;

	a_idle_no_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !div_rsp.done)
		else $error("divider finished with no item in flight");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready && start_q)
		else $error("transfer in did not start the divider");

	a_last_step: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV && div_rsp.done && step_q == STEP_1Y |=> state_q == S_YEAR)
		else $error("sequencer missed the year stage");

	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> month != 4'd0 && month <= 4'd12 && day != 5'd0 && hour <= 5'd23)
		else $error("result field out of range");

endmodule
